### rtl/dppd_pkg.sv
// Shared types, constants and the angle table for the depth phase pixel decoder.
package dppd_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = 5;
    localparam int CH_W          = 8;
    localparam int REG_W         = 16;
    localparam int XY_W          = 24;
    localparam int Z_W           = 18;
    localparam int ANG_W         = 14;
    localparam int DEPTH_W       = 18;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_Z_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_MIN   = 2'd1;

    localparam logic [REG_W-1:0] Z_RANGE_RST = 16'd32000;
    localparam logic [REG_W-1:0] Z_MIN_RST   = 16'd9600;

    localparam logic signed [Z_W-1:0] HALF_TURN = 18'sd32768;

    localparam logic signed [DEPTH_W-1:0] DEPTH_LOW  = -18'sd2048;
    localparam logic signed [DEPTH_W-1:0] DEPTH_HIGH = 18'sd131071;

    // One CORDIC step: valid flag and coarse code plus the vector and angle so far.
    typedef struct packed {
        logic                   vld;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [CH_W-1:0]        co;
    } t_cell;

    // atan(2^-i) in units of 2^-16 turn
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STAGE_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 14'd8192;
            5'd1:    v = 14'd4836;
            5'd2:    v = 14'd2555;
            5'd3:    v = 14'd1297;
            5'd4:    v = 14'd651;
            5'd5:    v = 14'd326;
            5'd6:    v = 14'd163;
            5'd7:    v = 14'd81;
            5'd8:    v = 14'd41;
            5'd9:    v = 14'd20;
            5'd10:   v = 14'd10;
            5'd11:   v = 14'd5;
            5'd12:   v = 14'd3;
            5'd13:   v = 14'd1;
            5'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/dppd_cordic_cell.sv
// One vectoring CORDIC cell: rotate toward the x axis and register the result.
module dppd_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [dppd_pkg::STAGE_W-1:0]  i_stage,
    input  dppd_pkg::t_cell               i_cell,
    output dppd_pkg::t_cell               o_cell
);

    dppd_pkg::t_cell                     r_cell;
    dppd_pkg::t_cell                     n_cell;
    logic signed [dppd_pkg::XY_W-1:0]    w_xs;
    logic signed [dppd_pkg::XY_W-1:0]    w_ys;
    logic signed [dppd_pkg::Z_W-1:0]     w_ang;

    assign w_xs  = i_cell.x >>> i_stage;
    assign w_ys  = i_cell.y >>> i_stage;
    assign w_ang = dppd_pkg::Z_W'($signed({1'b0, dppd_pkg::atan_turn(i_stage)}));

    always_comb begin
        n_cell = i_cell;
        if (!i_cell.y[dppd_pkg::XY_W-1]) begin
            n_cell.x = i_cell.x + w_ys;
            n_cell.y = i_cell.y - w_xs;
            n_cell.z = i_cell.z + w_ang;
        end else begin
            n_cell.x = i_cell.x - w_ys;
            n_cell.y = i_cell.y + w_xs;
            n_cell.z = i_cell.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

### rtl/dppd_order_unit.sv
// Fringe order from the coarse phase, depth rounding and saturation.
module dppd_order_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  dppd_pkg::t_cell                      i_cell,
    input  logic [dppd_pkg::REG_W-1:0]           i_z_range,
    input  logic [dppd_pkg::REG_W-1:0]           i_z_min,
    output logic                                 o_vld,
    output logic signed [dppd_pkg::DEPTH_W-1:0]  o_depth
);

    localparam int PROD_W = dppd_pkg::CH_W + dppd_pkg::REG_W;
    localparam int NUM_W  = PROD_W + 9;
    localparam int F255_W = dppd_pkg::Z_W + 8;
    localparam int B_W    = NUM_W - 16;
    localparam int QP_W   = B_W + 16;
    localparam int Q_W    = QP_W - 23;
    localparam int N_W    = Q_W + 1;
    localparam int T_W    = 28;
    localparam logic [NUM_W-1:0] HALF_DEN = 33'd8355840;
    localparam logic [15:0]      RECIP    = 16'd32897;

    // stage 1: coarse product
    logic                               r1_vld;
    logic [PROD_W-1:0]                  r1_prod;
    logic signed [dppd_pkg::Z_W-1:0]    r1_f;
    // stage 2: signed numerator
    logic                               r2_vld;
    logic signed [NUM_W-1:0]            r2_num;
    logic signed [dppd_pkg::Z_W-1:0]    r2_f;
    // stage 3: rounded magnitude over 2^16
    logic                               r3_vld;
    logic [B_W-1:0]                     r3_b;
    logic                               r3_neg;
    logic signed [dppd_pkg::Z_W-1:0]    r3_f;
    // stage 4: fringe order
    logic                               r4_vld;
    logic signed [N_W-1:0]              r4_n;
    logic signed [dppd_pkg::Z_W-1:0]    r4_f;
    // stage 5: result
    logic                               r5_vld;
    logic signed [dppd_pkg::DEPTH_W-1:0] r5_depth;

    logic signed [F255_W-1:0]           w_f255;
    logic signed [NUM_W-1:0]            w_num;
    logic [NUM_W-1:0]                   w_mag;
    logic [NUM_W-1:0]                   w_a;
    logic [QP_W-1:0]                    w_qp;
    logic [Q_W-1:0]                     w_q;
    logic signed [N_W-1:0]              w_n;
    logic signed [T_W-1:0]              w_t;
    logic signed [T_W-1:0]              w_d;
    logic signed [dppd_pkg::DEPTH_W-1:0] w_depth;

    assign w_f255 = (F255_W'(r1_f) <<< 8) - F255_W'(r1_f);
    assign w_num  = $signed({2'b00, r1_prod, 7'b0}) - NUM_W'(w_f255);

    assign w_mag  = r2_num[NUM_W-1] ? NUM_W'(-r2_num) : NUM_W'(r2_num);
    assign w_a    = w_mag + HALF_DEN;

    // divide by 255 via reciprocal; exact over the range of values that reach this stage
    assign w_qp   = QP_W'(r3_b) * QP_W'(RECIP);
    assign w_q    = w_qp[QP_W-1:23];
    assign w_n    = r3_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    assign w_t    = T_W'($signed({1'b0, i_z_min, 7'b0})) + (T_W'(r4_n) <<< 16)
                  + T_W'(r4_f) + T_W'(64);
    assign w_d    = w_t >>> 7;

    always_comb begin
        if (w_d < T_W'(dppd_pkg::DEPTH_LOW)) begin
            w_depth = dppd_pkg::DEPTH_LOW;
        end else if (w_d > T_W'(dppd_pkg::DEPTH_HIGH)) begin
            w_depth = dppd_pkg::DEPTH_HIGH;
        end else begin
            w_depth = w_d[dppd_pkg::DEPTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_cell.vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= PROD_W'(i_cell.co) * PROD_W'(i_z_range);
            r1_f     <= i_cell.z;
            r2_num   <= w_num;
            r2_f     <= r1_f;
            r3_b     <= w_a[NUM_W-1:16];
            r3_neg   <= r2_num[NUM_W-1];
            r3_f     <= r2_f;
            r4_n     <= w_n;
            r4_f     <= r3_f;
            r5_depth <= w_depth;
        end
    end

    assign o_vld   = r5_vld;
    assign o_depth = r5_depth;

endmodule

### rtl/depth_phase_pixel_decoder_unit.sv
// Top level of the depth phase pixel decoder: input stage, CORDIC chain, order unit.
// Pipeline: input register, then the CORDIC cell chain, then the order stages.
// Throughput: one pixel per cycle; the CORDIC cell chain and order stages advance
// together whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears all valid flags and loads z_range = 32000
// and z_min = 9600. Configuration writes are always taken.
module depth_phase_pixel_decoder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [dppd_pkg::CH_W-1:0]            i_chan_fine_sin,
    input  logic [dppd_pkg::CH_W-1:0]            i_chan_fine_cos,
    input  logic [dppd_pkg::CH_W-1:0]            i_chan_coarse,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [dppd_pkg::DEPTH_W-1:0]  o_depth_q4,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dppd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dppd_pkg::REG_W-1:0]           i_cfg_data
);

    localparam int D_W = dppd_pkg::CH_W + 2;

    logic [dppd_pkg::REG_W-1:0]        r_z_range;
    logic [dppd_pkg::REG_W-1:0]        r_z_min;
    logic                              w_adv;
    logic                              w_out_vld;
    logic signed [D_W-1:0]             w_cs2;
    logic signed [D_W-1:0]             w_sn2;
    logic signed [dppd_pkg::XY_W-1:0]  w_x0;
    logic signed [dppd_pkg::XY_W-1:0]  w_y0;
    dppd_pkg::t_cell                   r_head;
    dppd_pkg::t_cell                   n_head;
    dppd_pkg::t_cell                   w_chain [0:dppd_pkg::CORDIC_STAGES];

    // advance the whole chain whenever the output slot frees up
    assign w_adv       = !w_out_vld || i_ready;
    assign o_ready     = w_adv;
    assign o_valid     = w_out_vld;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_range <= dppd_pkg::Z_RANGE_RST;
            r_z_min   <= dppd_pkg::Z_MIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dppd_pkg::REG_Z_RANGE: r_z_range <= i_cfg_data;
                dppd_pkg::REG_Z_MIN:   r_z_min   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cs2 = $signed({1'b0, i_chan_fine_cos, 1'b0}) - D_W'(255);
    assign w_sn2 = $signed({1'b0, i_chan_fine_sin, 1'b0}) - D_W'(255);
    assign w_x0  = dppd_pkg::XY_W'(w_cs2) <<< 12;
    assign w_y0  = dppd_pkg::XY_W'(w_sn2) <<< 12;

    // turn a left-half vector by a half turn before the iterations
    always_comb begin
        n_head.vld = i_valid;
        n_head.co  = i_chan_coarse;
        if (w_x0[dppd_pkg::XY_W-1]) begin
            n_head.x = -w_x0;
            n_head.y = -w_y0;
            n_head.z = w_y0[dppd_pkg::XY_W-1] ? -dppd_pkg::HALF_TURN : dppd_pkg::HALF_TURN;
        end else begin
            n_head.x = w_x0;
            n_head.y = w_y0;
            n_head.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    for (genvar g = 0; g < dppd_pkg::CORDIC_STAGES; g++) begin : g_cell
        dppd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_stage (dppd_pkg::STAGE_W'(g)),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    dppd_order_unit u_order (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_cell    (w_chain[dppd_pkg::CORDIC_STAGES]),
        .i_z_range (r_z_range),
        .i_z_min   (r_z_min),
        .o_vld     (w_out_vld),
        .o_depth   (o_depth_q4)
    );

endmodule
